// ----- src/mbp_pkg.sv -----
package mbp_pkg;

    localparam int FIELD_W        = 64;
    localparam int BITS_W         = 7;
    localparam int BYTE_W         = 8;
    localparam int FILL_W         = 3;
    localparam int SHIFT_W        = 6;
    localparam int MAX_FIELD_BITS = 64;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [FILL_W-1:0]  t_fill;
    typedef logic [BITS_W-1:0]  t_bits;
    typedef logic [FIELD_W-1:0] t_field;

endpackage

// ----- src/mbp_in_if.sv -----
interface mbp_in_if
    import mbp_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   command;
    t_field field_value;
    t_bits  field_bits;

    modport source (output valid, output command, output field_value, output field_bits,
                    input ready);
    modport sink   (input valid, input command, input field_value, input field_bits,
                    output ready);
endinterface

// ----- src/mbp_out_if.sv -----
interface mbp_out_if
    import mbp_pkg::*;
();
    logic        valid;
    logic        ready;
    t_byte       data_byte;
    logic        is_padded;
    logic [2:0]  pad_bits;
    logic        last_of_run;

    modport source (output valid, output data_byte, output is_padded, output pad_bits,
                    output last_of_run, input ready);
    modport sink   (input valid, input data_byte, input is_padded, input pad_bits,
                    input last_of_run, output ready);
endinterface

// ----- src/msb_first_bit_packer.sv -----
// An add beat is accepted in idle; the add state then emits its bytes one at a time
// and closes by folding the leftover bits into the partial byte. A flush with a partial
// byte emits it padded from the flush state; an empty flush or a zero-width add is
// taken in idle. Throughput: one output byte per cycle while the output is not stalled,
// from a single byte-extract and shift unit; the input is not ready while a beat is being worked off.
// Synchronous active-low reset clears the partial byte, fill count, sequencer and output valid.
module msb_first_bit_packer
    import mbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbp_in_if.sink    i_in,
    mbp_out_if.source o_out
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ADD   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]   r_state,     n_state;
    t_field       r_val,       n_val;
    t_bits        r_left,      n_left;
    t_byte        r_acc,       n_acc;
    t_fill        r_fill,      n_fill;
    logic         r_out_valid, n_out_valid;
    t_byte        r_out_byte,  n_out_byte;
    logic         r_out_pad,   n_out_pad;
    logic [2:0]   r_out_npad,  n_out_npad;
    logic         r_out_last,  n_out_last;

    logic         w_slot_free;
    t_bits        w_nb;
    logic [SHIFT_W-1:0] w_sh;
    t_byte        w_byte;
    logic [3:0]   w_take;
    t_bits        w_rem;
    logic         w_emit;

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_nb  = (i_in.field_bits > BITS_W'(MAX_FIELD_BITS)) ?
                   BITS_W'(MAX_FIELD_BITS) : i_in.field_bits;
    assign w_sh  = SHIFT_W'(BITS_W'(FIELD_W) - w_nb);
    assign w_byte = (r_acc | (r_val[FIELD_W-1 -: BYTE_W] >> r_fill)) & BYTE_MASK;
    assign w_take = 4'd8 - {1'b0, r_fill};
    assign w_rem  = r_left - {3'd0, w_take};
    assign w_emit = ({5'd0, r_fill} + {1'b0, r_left}) >= 8'd8;

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_left      = r_left;
        n_acc       = r_acc;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_pad   = r_out_pad;
        n_out_npad  = r_out_npad;
        n_out_last  = r_out_last;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.command == CMD_FLUSH) begin
                        if (r_fill != '0) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_acc  = '0;
                            n_fill = '0;
                        end
                    end else if (w_nb != '0) begin
                        n_val   = i_in.field_value << w_sh;
                        n_left  = w_nb;
                        n_state = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                if (w_emit) begin
                    if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = w_byte;
                        n_out_pad   = 1'b0;
                        n_out_npad  = '0;
                        n_out_last  = (w_rem < 7'd8);
                        n_val       = r_val << w_take;
                        n_left      = w_rem;
                        n_acc       = '0;
                        n_fill      = '0;
                    end
                end else begin
                    n_acc   = w_byte;
                    n_fill  = r_fill + r_left[FILL_W-1:0];
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_acc;
                    n_out_pad   = 1'b1;
                    n_out_npad  = 3'(4'd8 - {1'b0, r_fill});
                    n_out_last  = 1'b1;
                    n_acc       = '0;
                    n_fill      = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_left     <= n_left;
        r_out_byte <= n_out_byte;
        r_out_pad  <= n_out_pad;
        r_out_npad <= n_out_npad;
        r_out_last <= n_out_last;
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.data_byte   = r_out_byte;
    assign o_out.is_padded   = r_out_pad;
    assign o_out.pad_bits    = r_out_npad;
    assign o_out.last_of_run = r_out_last;

endmodule

// ----- src/mbp_checker.sv -----
module mbp_checker
    import mbp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_command,
    input t_bits       i_in_field_bits,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_is_padded,
    input logic [2:0]  i_out_pad_bits,
    input logic        i_out_last_of_run
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output beat present right after reset.");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Output beat dropped while stalled.");

    a_padded_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_is_padded |-> i_out_last_of_run && i_out_pad_bits != 3'd0)
        else $error("Padded byte is not the last of its run.");

    a_full_no_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_is_padded |-> i_out_pad_bits == 3'd0)
        else $error("Full byte reports padding bits.");

    a_busy_after_wide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_command == CMD_ADD && i_in_field_bits >= 7'd8
        |=> !i_in_ready)
        else $error("Input ready while a wide field is being packed.");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_command      (i_in.command),
    .i_in_field_bits   (i_in.field_bits),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_is_padded   (o_out.is_padded),
    .i_out_pad_bits    (o_out.pad_bits),
    .i_out_last_of_run (o_out.last_of_run)
);

// ----- sim/tb_msb_first_bit_packer.sv -----
module tb_msb_first_bit_packer;
    import mbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_AT_BEAT = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_CMDS  = 460;

    typedef struct {
        logic   command;
        t_field field_value;
        t_bits  field_bits;
    } t_pack_cmd;

    typedef struct {
        t_byte      data_byte;
        logic       is_padded;
        logic [2:0] pad_bits;
        logic       last_of_run;
    } t_out_byte;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mbp_in_if  in_if ();
    mbp_out_if out_if ();

    msb_first_bit_packer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_pack_cmd pending_cmds_q[$];
    t_out_byte expected_bytes_q[$];
    t_pack_cmd cur_cmd;
    t_byte     held_byte = '0;
    t_fill     held_fill = '0;
    int        n_cmds = 0;
    int        n_accepted = 0;
    int        n_errors = 0;
    int        burst_left = 1;
    int        gap_left = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    int        rx_mode = 0;
    logic [5:0] rx_cycle = '0;
    int        idle_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void pack_into_bytes(input t_pack_cmd c);
        t_byte       acc;
        int unsigned fill;
        int unsigned nbits;
        int unsigned n;
        t_byte       done[8];
        acc = held_byte;
        fill = held_fill;
        n = 0;
        if (c.command == CMD_FLUSH) begin
            if (fill != 0)
                expected_bytes_q.push_back('{acc, 1'b1, 3'(8 - fill), 1'b1});
            held_byte = '0;
            held_fill = '0;
            return;
        end
        nbits = (c.field_bits > MAX_FIELD_BITS) ? MAX_FIELD_BITS : c.field_bits;
        for (int i = nbits; i > 0; i--) begin
            acc[7 - fill] = c.field_value[i - 1];
            fill++;
            if (fill == 8) begin
                done[n] = acc;
                n++;
                acc = '0;
                fill = 0;
            end
        end
        for (int k = 0; k < n; k++)
            expected_bytes_q.push_back('{done[k], 1'b0, 3'd0, (k == n - 1)});
        held_byte = acc;
        held_fill = fill[FILL_W-1:0];
    endfunction

    function automatic void queue_add(input t_field value, input t_bits nbits);
        pending_cmds_q.push_back('{CMD_ADD, value, nbits});
    endfunction

    function automatic void queue_flush(input t_field value, input t_bits nbits);
        pending_cmds_q.push_back('{CMD_FLUSH, value, nbits});
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                pack_into_bytes(cur_cmd);
                n_accepted <= n_accepted + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0 || pending_cmds_q.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    in_if.valid <= 1'b0;
                end else begin
                    cur_cmd = pending_cmds_q.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.command     <= cur_cmd.command;
                    in_if.field_value <= cur_cmd.field_value;
                    in_if.field_bits  <= cur_cmd.field_bits;
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
                    end
                end
            end
        end
    end

    // The long hold-off lets the sender keep offering beats until the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT_BEAT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else begin
            if (rx_cycle == 0)
                rx_mode = $urandom_range(0, 3);
            rx_cycle++;
            case (rx_mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= 1'($urandom_range(0, 1));
                2: out_if.ready <= ($urandom_range(0, 3) == 0);
                default: out_if.ready <= rx_cycle[3];
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_byte exp_byte;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_bytes_q.size() == 0) begin
                $error("unexpected byte %0h with no expectation pending", out_if.data_byte);
                n_errors++;
            end else begin
                exp_byte = expected_bytes_q.pop_front();
                if (out_if.data_byte !== exp_byte.data_byte) begin
                    $error("data_byte: expected %0h, got %0h",
                           exp_byte.data_byte, out_if.data_byte);
                    n_errors++;
                end
                if (out_if.is_padded !== exp_byte.is_padded) begin
                    $error("is_padded: expected %0b, got %0b",
                           exp_byte.is_padded, out_if.is_padded);
                    n_errors++;
                end
                if (out_if.pad_bits !== exp_byte.pad_bits) begin
                    $error("pad_bits: expected %0d, got %0d",
                           exp_byte.pad_bits, out_if.pad_bits);
                    n_errors++;
                end
                if (out_if.last_of_run !== exp_byte.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           exp_byte.last_of_run, out_if.last_of_run);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_field value;
        t_bits  nbits;
        in_if.valid = 1'b0;
        in_if.command = CMD_ADD;
        in_if.field_value = '0;
        in_if.field_bits = '0;
        out_if.ready = 1'b0;

        queue_add('1, 7'd0);
        queue_flush('0, 7'd0);
        queue_add('1, 7'd64);
        queue_add('0, 7'd64);
        queue_add(64'h0123_4567_89AB_CDEF, 7'd127);
        queue_add(64'hFEDC_BA98_7654_3210, 7'd65);
        queue_add(64'hFFFF_FFFF_FFFF_FFFD, 7'd3);
        queue_add(64'hA5A5_A5A5_A5A5_A5A5, 7'd64);
        queue_flush('1, 7'd127);
        queue_add(64'h1, 7'd1);
        queue_flush('0, 7'd0);
        queue_add(64'h7F, 7'd7);
        queue_flush('0, 7'd5);
        queue_add(64'h55, 7'd7);
        queue_add(64'h1, 7'd1);
        queue_add(64'h7F, 7'd7);
        queue_add('1, 7'd64);
        queue_flush('0, 7'd0);
        queue_add(64'h5A, 7'd8);
        queue_add(64'hC, 7'd4);
        queue_add('0, 7'd0);
        queue_flush(64'h8000_0000_0000_0000, 7'd64);
        queue_flush('0, 7'd0);

        for (int i = 0; i < RANDOM_CMDS; i++) begin
            case ($urandom_range(0, 7))
                0: value = '1;
                1: value = '0;
                default: value = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 19))
                0: nbits = 7'd0;
                1, 2: nbits = 7'($urandom_range(65, 127));
                3, 4: nbits = 7'd64;
                5, 6, 7, 8: nbits = 7'($urandom_range(1, 8));
                default: nbits = 7'($urandom_range(1, 63));
            endcase
            if ($urandom_range(0, 7) == 0)
                queue_flush(value, nbits);
            else
                queue_add(value, nbits);
        end
        n_cmds = pending_cmds_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_accepted == n_cmds);
        while (expected_bytes_q.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
